// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the dispatch table RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ptdt_pkg.sv =====
// Package for the periodic task dispatch table: op and status codes,
// entry record and controller/datapath command and status structs. No dependencies.
package ptdt_pkg;

    localparam int DEF_MAX_ENTRIES = 32;

    localparam logic [3:0] OP_POLL    = 4'd0;
    localparam logic [3:0] OP_ADD     = 4'd1;
    localparam logic [3:0] OP_DELETE  = 4'd2;
    localparam logic [3:0] OP_SET_RUN = 4'd3;
    localparam logic [3:0] OP_SET_ALL = 4'd4;
    localparam logic [3:0] OP_SET_PER = 4'd5;
    localparam logic [3:0] OP_REPLACE = 4'd6;
    localparam logic [3:0] OP_CLEAR   = 4'd7;
    localparam logic [3:0] OP_COMPACT = 4'd8;
    localparam logic [3:0] OP_DEDUPE  = 4'd9;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_NO_TASKS  = 2'd3;

    typedef struct packed {
        logic [15:0] key;
        logic [15:0] period;
        logic [31:0] due;
        logic        run;
    } t_entry;

    typedef struct packed {
        logic load;
        logic rd;
        logic ev;
        logic ird;
        logic iev;
    } t_cmd;

    typedef struct packed {
        logic imm;
        logic done;
        logic inner;
    } t_sts;

endpackage

// ===== rtl/ptdt_ctrl.sv =====
// Controller state machine for the dispatch table.
// Depends on ptdt_pkg (command/status structs) and assert_macros.svh.
`include "assert_macros.svh"
module ptdt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    output logic           o_strobe,
    input  ptdt_pkg::t_sts i_sts,
    output ptdt_pkg::t_cmd o_cmd
);
    import ptdt_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_EV   = 3'd2;
    localparam logic [2:0] S_IRD  = 3'd3;
    localparam logic [2:0] S_IEV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.imm ? S_OUT : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV, S_IEV: begin
                o_cmd.ev  = (r_state == S_EV);
                o_cmd.iev = (r_state == S_IEV);
                priority if (i_sts.done) n_state = S_OUT;
                else if (i_sts.inner)    n_state = S_IRD;
                else                     n_state = S_RD;
            end
            S_IRD: begin
                o_cmd.ird = 1'b1;
                n_state   = S_IEV;
            end
            S_OUT: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

    `ASSERT_NEXT(a_out_one_cycle, r_state == S_OUT, r_state == S_IDLE)
    `ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
    `ASSERT_IMPL(a_cmd_onehot, 1'b1, $onehot0(o_cmd))

endmodule

// ===== rtl/ptdt_datapath.sv =====
// Datapath for the dispatch table: entry memory, valid bits, counters, results.
// Depends on ptdt_pkg (codes, entry record, structs) and assert_macros.svh.
`include "assert_macros.svh"
module ptdt_datapath #(
    parameter int MAX_ENTRIES = ptdt_pkg::DEF_MAX_ENTRIES
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ptdt_pkg::t_cmd i_cmd,
    output ptdt_pkg::t_sts o_sts,
    input  logic [3:0]     i_op,
    input  logic [31:0]    i_now_ms,
    input  logic [15:0]    i_key,
    input  logic [15:0]    i_new_key,
    input  logic [15:0]    i_period,
    input  logic           i_run_flag,
    output logic [1:0]     o_status,
    output logic           o_dispatch,
    output logic [15:0]    o_dispatch_key,
    output logic [4:0]     o_dispatch_slot,
    output logic [5:0]     o_entry_count
);
    import ptdt_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_ENTRIES - 1);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd;
    logic   r_rd_vld;
    t_entry d;

    logic [MAX_ENTRIES-1:0] r_valid, n_valid;
    logic [CW-1:0] r_count, n_count, r_ptr, n_ptr;
    logic [CW-1:0] r_i, n_i, r_j, n_j, r_slot, n_slot;
    logic [15:0]   r_ref, n_ref;
    logic [3:0]    r_op;
    logic [31:0]   r_now;
    logic [15:0]   r_key, r_nkey, r_per;
    logic          r_run;
    logic [1:0]    r_status, n_status;
    logic          r_disp, n_disp;
    logic [15:0]   r_dkey, n_dkey;

    logic          w_en;
    logic [IW-1:0] w_addr;
    t_entry        w_data;
    logic [IW-1:0] rd_addr;
    logic          lookup_op, i_last, j_last, i_last2;
    logic          imm_op;
    logic [CW-1:0] jn;
    logic [63:0]   slot_ext, count_ext;

    assign d         = r_rd_vld ? r_rd : '0;
    assign lookup_op = (r_op == OP_DELETE) || (r_op == OP_SET_RUN) ||
                       (r_op == OP_SET_PER) || (r_op == OP_REPLACE);
    assign i_last    = ((CW+1)'(r_i) + (CW+1)'(1)) >= (CW+1)'(r_count);
    assign i_last2   = ((CW+1)'(r_i) + (CW+1)'(2)) >= (CW+1)'(r_count);
    assign j_last    = ((CW+1)'(r_j) + (CW+1)'(1)) >= (CW+1)'(r_count);
    assign jn        = (d.key != 16'd0) ? r_j + 1'b1 : r_j;
    assign rd_addr   = i_cmd.ird ? r_j[IW-1:0] : r_i[IW-1:0];

    always_comb begin
        imm_op = (r_count == '0) ? ((i_op == OP_POLL) || (i_op == OP_DELETE) ||
                 (i_op == OP_SET_RUN) || (i_op == OP_SET_PER) || (i_op == OP_REPLACE) ||
                 (i_op == OP_COMPACT) || (i_op == OP_DEDUPE)) : 1'b0;
        imm_op = imm_op || (i_op == OP_ADD) || (i_op == OP_CLEAR) || (i_op > OP_DEDUPE);
    end

    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_i      = r_i;
        n_j      = r_j;
        n_ref    = r_ref;
        n_slot   = r_slot;
        n_status = r_status;
        n_disp   = r_disp;
        n_dkey   = r_dkey;
        n_valid  = r_valid;
        w_en     = 1'b0;
        w_addr   = r_i[IW-1:0];
        w_data   = d;
        o_sts.imm   = imm_op;
        o_sts.done  = 1'b0;
        o_sts.inner = 1'b0;
        if (i_cmd.load) begin
            n_status = ST_OK;
            n_disp   = 1'b0;
            n_dkey   = '0;
            n_slot   = '0;
            n_i      = '0;
            n_j      = '0;
            case (i_op)
                OP_POLL: begin
                    if (r_count == '0) n_status = ST_NO_TASKS;
                    else n_i = (r_ptr >= r_count) ? '0 : r_ptr;
                end
                OP_ADD: begin
                    if (r_count >= MAX_C) begin
                        n_status = ST_FULL;
                    end else begin
                        w_en   = 1'b1;
                        w_addr = r_count[IW-1:0];
                        w_data = '{key: i_key, period: i_period, due: 32'd0, run: i_run_flag};
                        n_count = r_count + 1'b1;
                        n_slot  = r_count;
                    end
                end
                OP_DELETE, OP_SET_RUN, OP_SET_PER, OP_REPLACE: begin
                    if (r_count == '0) n_status = ST_NOT_FOUND;
                end
                OP_CLEAR: begin
                    n_valid = '0;
                    n_count = '0;
                    n_ptr   = '0;
                end
                default: ;
            endcase
        end else if (i_cmd.ev) begin
            if (r_op == OP_POLL) begin
                n_slot = r_i;
                if (d.key != 16'd0 && d.run && d.due <= r_now) begin
                    n_disp = 1'b1;
                    n_dkey = d.key;
                    w_en   = 1'b1;
                    w_data.due = r_now + {16'd0, d.period};
                end
                n_ptr = i_last ? '0 : r_i + 1'b1;
                o_sts.done = 1'b1;
            end else if (lookup_op) begin
                if (d.key == r_key) begin
                    w_en   = 1'b1;
                    n_slot = r_i;
                    case (r_op)
                        OP_DELETE:  w_data.key = 16'd0;
                        OP_SET_RUN: w_data.run = r_run;
                        OP_SET_PER: begin
                            w_data.period = r_per;
                            w_data.due    = r_now + {16'd0, r_per};
                        end
                        default: begin
                            w_data = '{key: r_nkey, period: r_per,
                                       due: r_now + {16'd0, r_per}, run: r_run};
                        end
                    endcase
                    o_sts.done = 1'b1;
                end else if (i_last) begin
                    n_status   = ST_NOT_FOUND;
                    o_sts.done = 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end else if (r_op == OP_SET_ALL) begin
                w_en       = 1'b1;
                w_data.run = r_run;
                if (r_i == LAST_C) o_sts.done = 1'b1;
                else n_i = r_i + 1'b1;
            end else if (r_op == OP_COMPACT) begin
                if (d.key != 16'd0) begin
                    w_en   = 1'b1;
                    w_addr = r_j[IW-1:0];
                end
                n_j = jn;
                if (i_last) begin
                    n_count = jn;
                    n_ptr   = (r_ptr >= jn) ? '0 : r_ptr;
                    for (int k = 0; k < MAX_ENTRIES; k++) begin
                        if (CW'(k) >= jn) n_valid[k] = 1'b0;
                    end
                    o_sts.done = 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end else if (r_op == OP_DEDUPE) begin
                if (d.key != 16'd0 && !i_last) begin
                    n_ref       = d.key;
                    n_j         = r_i + 1'b1;
                    o_sts.inner = 1'b1;
                end else if (i_last) begin
                    o_sts.done = 1'b1;
                end else begin
                    n_i = r_i + 1'b1;
                end
            end else begin
                o_sts.done = 1'b1;
            end
        end else if (i_cmd.iev) begin
            w_addr = r_j[IW-1:0];
            if (d.key == r_ref) begin
                w_en       = 1'b1;
                w_data.key = 16'd0;
            end
            if (j_last) begin
                if (i_last2) o_sts.done = 1'b1;
                else n_i = r_i + 1'b1;
            end else begin
                n_j         = r_j + 1'b1;
                o_sts.inner = 1'b1;
            end
        end
        if (w_en) n_valid[w_addr] = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) r_mem[w_addr] <= w_data;
        if (i_cmd.rd || i_cmd.ird) begin
            r_rd     <= r_mem[rd_addr];
            r_rd_vld <= r_valid[rd_addr];
        end
        if (i_cmd.load) begin
            r_op   <= i_op;
            r_now  <= i_now_ms;
            r_key  <= i_key;
            r_nkey <= i_new_key;
            r_per  <= i_period;
            r_run  <= i_run_flag;
        end
        r_i      <= n_i;
        r_j      <= n_j;
        r_ref    <= n_ref;
        r_slot   <= n_slot;
        r_status <= n_status;
        r_disp   <= n_disp;
        r_dkey   <= n_dkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
            r_ptr   <= '0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            r_ptr   <= n_ptr;
        end
    end

    assign slot_ext        = 64'(r_slot);
    assign count_ext       = 64'(r_count);
    assign o_status        = r_status;
    assign o_dispatch      = r_disp;
    assign o_dispatch_key  = r_dkey;
    assign o_dispatch_slot = slot_ext[4:0];
    assign o_entry_count   = count_ext[5:0];

    `ASSERT_IMPL(a_count_range, 1'b1, r_count <= MAX_C)
    `ASSERT_IMPL(a_ptr_range, 1'b1, (r_ptr == '0) || (r_ptr < r_count))
    `ASSERT_IMPL(a_single_write, i_cmd.rd || i_cmd.ird, !w_en)

endmodule

// ===== rtl/periodic_task_dispatch_table.sv =====
// Periodic task dispatch table, top level: controller plus datapath.
// Add, clear, unknown ops, and other ops except set-all on an empty table, go straight to the strobe;
// other ops read and evaluate entries one at a time: poll one entry, lookups until a match,
// set-all all MAX_ENTRIES slots, compact every entry, dedupe each nonzero entry against later ones.
// One item at a time; busy stays high through the result strobe; receiver cannot stall.
// Reset (synchronous, active low) empties the table at once via valid bits.
module periodic_task_dispatch_table #(
    parameter int MAX_ENTRIES = ptdt_pkg::DEF_MAX_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_op,
    input  logic [31:0] i_now_ms,
    input  logic [15:0] i_key,
    input  logic [15:0] i_new_key,
    input  logic [15:0] i_period,
    input  logic        i_run_flag,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic        o_dispatch,
    output logic [15:0] o_dispatch_key,
    output logic [4:0]  o_dispatch_slot,
    output logic [5:0]  o_entry_count
);
    import ptdt_pkg::*;

    t_cmd cmd;
    t_sts sts;

    ptdt_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .o_strobe (o_strobe),
        .i_sts    (sts),
        .o_cmd    (cmd)
    );

    ptdt_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_op            (i_op),
        .i_now_ms        (i_now_ms),
        .i_key           (i_key),
        .i_new_key       (i_new_key),
        .i_period        (i_period),
        .i_run_flag      (i_run_flag),
        .o_status        (o_status),
        .o_dispatch      (o_dispatch),
        .o_dispatch_key  (o_dispatch_key),
        .o_dispatch_slot (o_dispatch_slot),
        .o_entry_count   (o_entry_count)
    );

endmodule
